// ----- rtl/matrix_inverse_4x4_top_defines.svh -----
// assertion macros for the 4x4 matrix inverse block
// used by matrix_inverse_4x4_top; needs a signal named clock and one named reset in scope
`ifndef MATRIX_INVERSE_4X4_TOP_DEFINES_SVH
`define MATRIX_INVERSE_4X4_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MINV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MINV_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define MINV_ASSERT(lbl, prop, msg)
`define MINV_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/minv_pkg.sv -----
// shared types, widths and helpers for the 4x4 matrix inverse block
// no dependencies
package minv_pkg;

   localparam int N          = 4;
   localparam int ELEM_W     = 16;
   localparam int M2_W       = 33;
   localparam int COF_W      = 52;
   localparam int DET_W      = 72;
   localparam int MAG_W      = 72;
   localparam int CM_W       = 52;
   localparam int FRAC_SHIFT = 24;
   localparam int NUM_W      = CM_W + FRAC_SHIFT;
   localparam int Q_W        = 31;
   localparam int TRY_W      = MAG_W + Q_W + 1;
   localparam int DIV_STAGES = Q_W + 1;

   localparam logic [1:0]  LAST_ROW = 2'd3;
   localparam logic [31:0] SAT_POS  = 32'h7fff_ffff;
   localparam logic [31:0] SAT_NEG  = 32'h8000_0000;

   typedef logic [N-1:0][N-1:0][ELEM_W-1:0] mat_type;
   typedef logic [N-1:0][ELEM_W-1:0]        col_type;
   typedef logic [N-1:0][N-1:0][COF_W-1:0]  cof_mat_type;
   typedef logic [N-1:0][N-1:0][CM_W-1:0]   cm_mat_type;

   typedef struct packed {
      logic valid;
      logic singular;
   } minv_det_ctl_type;

   typedef struct packed {
      logic                       valid;
      logic [1:0]                 row;
      logic                       singular;
      logic [N-1:0]               neg;
      logic [N-1:0]               sat;
      logic [MAG_W-1:0]           dmag;
      logic [N-1:0][NUM_W-1:0]    rem;
      logic [N-1:0][Q_W-1:0]      quo;
   } minv_div_stage_type;

   // index k of the kept rows/columns once x is struck out
   function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] x);
      return (k < x) ? k : k + 2'd1;
   endfunction

endpackage

// ----- rtl/minv_cofactor.sv -----
// input register plus two stages: 2x2 minors, then signed 3x3 cofactors
// depends on minv_pkg
module minv_cofactor import minv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  mat_type     in_mat,
   output logic        cof_valid,
   output cof_mat_type cof,
   output col_type     cof_col0
);

   mat_type mat_ff;
   logic    v0_ff, va_ff, vb_ff;
   logic [N-1:0][N-1:0][2:0][M2_W-1:0]   m2_in, m2_ff;
   logic [N-1:0][N-1:0][2:0][ELEM_W-1:0] top_in, top_ff;
   col_type     col_a_ff, col_b_ff;
   cof_mat_type cof_in, cof_ff;

   // 2x2 minors of the lower two rows of each 3x3 sub-matrix
   always_comb begin
      logic signed [ELEM_W-1:0] s [3][3];
      for (int r = 0; r < N; r++) begin
         for (int c = 0; c < N; c++) begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  s[i][j] = $signed(mat_ff[skip_idx(2'(i), 2'(r))][skip_idx(2'(j), 2'(c))]);
               end
            end
            m2_in[r][c][0] = M2_W'(s[1][1]) * M2_W'(s[2][2]) - M2_W'(s[1][2]) * M2_W'(s[2][1]);
            m2_in[r][c][1] = M2_W'(s[1][0]) * M2_W'(s[2][2]) - M2_W'(s[1][2]) * M2_W'(s[2][0]);
            m2_in[r][c][2] = M2_W'(s[1][0]) * M2_W'(s[2][1]) - M2_W'(s[1][1]) * M2_W'(s[2][0]);
            for (int j = 0; j < 3; j++) begin
               top_in[r][c][j] = s[0][j];
            end
         end
      end
   end

   // expand along the top row, alternating sign by position
   always_comb begin
      logic signed [COF_W-1:0] d;
      for (int r = 0; r < N; r++) begin
         for (int c = 0; c < N; c++) begin
            d = COF_W'($signed(top_ff[r][c][0])) * COF_W'($signed(m2_ff[r][c][0]))
              - COF_W'($signed(top_ff[r][c][1])) * COF_W'($signed(m2_ff[r][c][1]))
              + COF_W'($signed(top_ff[r][c][2])) * COF_W'($signed(m2_ff[r][c][2]));
            cof_in[r][c] = ((r + c) % 2 == 1) ? -d : d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         va_ff <= v0_ff;
         vb_ff <= va_ff;
      end
      if (in_valid) begin
         mat_ff <= in_mat;
      end
      m2_ff  <= m2_in;
      top_ff <= top_in;
      cof_ff <= cof_in;
      for (int r = 0; r < N; r++) begin
         col_a_ff[r] <= mat_ff[r][0];
      end
      col_b_ff <= col_a_ff;
   end

   assign cof_valid = vb_ff;
   assign cof       = cof_ff;
   assign cof_col0  = col_b_ff;

endmodule

// ----- rtl/minv_det.sv -----
// determinant by first-column expansion, then magnitudes, signs and singular flag
// depends on minv_pkg
module minv_det import minv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             cof_valid,
   input  cof_mat_type      cof,
   input  col_type          cof_col0,
   output minv_det_ctl_type det_ctl,
   output logic [MAG_W-1:0] dmag,
   output cm_mat_type       cm,
   output logic [N-1:0][N-1:0] neg
);

   logic signed [DET_W-1:0] det_in, det_ff;
   cof_mat_type             cof_c_ff;
   logic                    vc_ff;
   minv_det_ctl_type        ctl_in, ctl_ff;
   logic [MAG_W-1:0]        dmag_in, dmag_ff;
   cm_mat_type              cm_in, cm_ff;
   logic [N-1:0][N-1:0]     neg_in, neg_ff;
   logic                    det_neg;

   always_comb begin
      det_in = '0;
      for (int r = 0; r < N; r++) begin
         det_in = det_in + DET_W'($signed(cof_col0[r])) * DET_W'($signed(cof[r][0]));
      end
   end

   // adjugate element (r,c) is the cofactor of (c,r)
   always_comb begin
      logic signed [COF_W-1:0] a;
      det_neg        = det_ff[DET_W-1];
      dmag_in        = det_neg ? MAG_W'(-det_ff) : MAG_W'(det_ff);
      ctl_in.valid    = vc_ff;
      ctl_in.singular = (det_ff == '0);
      for (int r = 0; r < N; r++) begin
         for (int c = 0; c < N; c++) begin
            a            = $signed(cof_c_ff[c][r]);
            cm_in[r][c]  = a[COF_W-1] ? CM_W'(-a) : CM_W'(a);
            neg_in[r][c] = a[COF_W-1] ^ det_neg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else begin
         vc_ff  <= cof_valid;
         ctl_ff <= ctl_in;
      end
      det_ff   <= det_in;
      cof_c_ff <= cof;
      dmag_ff  <= dmag_in;
      cm_ff    <= cm_in;
      neg_ff   <= neg_in;
   end

   assign det_ctl = ctl_ff;
   assign dmag    = dmag_ff;
   assign cm      = cm_ff;
   assign neg     = neg_ff;

endmodule

// ----- rtl/minv_divider.sv -----
// pipelined restoring divider, four columns side by side, a saturation check then one quotient bit per stage
// depends on minv_pkg
module minv_divider import minv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  minv_div_stage_type div_in,
   output minv_div_stage_type div_out
);

   minv_div_stage_type stage_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      minv_div_stage_type src, nxt;

      if (k == 0) begin : g_first
         assign src = div_in;
         // quotient of 2^31 or more saturates
         always_comb begin
            logic [TRY_W-1:0] shifted;
            nxt     = src;
            shifted = TRY_W'(src.dmag) << Q_W;
            for (int c = 0; c < N; c++) begin
               nxt.sat[c] = TRY_W'(src.rem[c]) >= shifted;
               nxt.quo[c] = '0;
            end
         end
      end else begin : g_step
         assign src = stage_ff[k-1];
         always_comb begin
            logic [TRY_W-1:0] shifted, ext;
            nxt     = src;
            shifted = TRY_W'(src.dmag) << (Q_W - k);
            for (int c = 0; c < N; c++) begin
               ext = TRY_W'(src.rem[c]);
               if (ext >= shifted) begin
                  nxt.rem[c]          = NUM_W'(ext - shifted);
                  nxt.quo[c][Q_W - k] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else begin
            stage_ff[k] <= nxt;
         end
      end
   end

   assign div_out = stage_ff[DIV_STAGES-1];

endmodule

// ----- rtl/matrix_inverse_4x4_top.sv -----
// top level of the 4x4 matrix inverse by adjugate and determinant
// depends on minv_pkg, minv_cofactor, minv_det, minv_divider and the defines header
`include "matrix_inverse_4x4_top_defines.svh"

// One transaction carries a whole 4x4 matrix of signed Q8.8 elements (column 0 in bits
// 15:0 of each row) and yields four result transactions, inverse rows 0 to 3 in order on
// consecutive cycles, each element signed Q16.16 truncated toward zero and saturated.
// A new matrix is taken only while busy is low; busy is raised after each start, since
// the four rows share one four-column divider pipeline, one row per cycle. Row 0 passes
// the cofactor, determinant, serialiser, divider and output registers, rows 1 to 3 behind.
// Results are strobed by rsp_valid for a single cycle and cannot be held off: the
// receiver must take every one. A zero determinant gives zero rows with rsp_singular set.
module matrix_inverse_4x4_top import minv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [63:0]        req_row_0,
   input  logic [63:0]        req_row_1,
   input  logic [63:0]        req_row_2,
   input  logic [63:0]        req_row_3,
   output logic               rsp_valid,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_col_0,
   output logic signed [31:0] rsp_col_1,
   output logic signed [31:0] rsp_col_2,
   output logic signed [31:0] rsp_col_3,
   output logic               rsp_singular,
   output logic               rsp_last_row
);

   // input side: a new transaction is taken only while busy is low
   logic       accept;
   logic [1:0] hold_cnt_ff, hold_cnt_in;
   mat_type    in_mat;

   // front end between modules
   logic               cof_valid;
   cof_mat_type        cof;
   col_type            cof_col0;
   minv_det_ctl_type   det_ctl;
   logic [MAG_W-1:0]   dmag;
   cm_mat_type         cm;
   logic [N-1:0][N-1:0] neg;

   // row serialiser holding one matrix worth of adjugate magnitudes
   cm_mat_type          hold_cm_ff;
   logic [N-1:0][N-1:0] hold_neg_ff;
   logic [MAG_W-1:0]    hold_dmag_ff;
   logic                hold_sing_ff;
   logic                ser_active_ff, ser_active_in;
   logic [1:0]          ser_row_ff, ser_row_in;

   minv_div_stage_type div_in, div_out;

   // output register
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_row_ff;
   logic                     rsp_sing_ff, rsp_last_ff;
   logic [N-1:0][31:0]       rsp_col_ff, rsp_col_in;

   assign accept = start && !busy;
   assign busy   = (hold_cnt_ff != 2'd0);

   always_comb begin
      hold_cnt_in = hold_cnt_ff;
      if (accept) begin
         hold_cnt_in = 2'd3;
      end else if (hold_cnt_ff != 2'd0) begin
         hold_cnt_in = hold_cnt_ff - 2'd1;
      end
   end

   assign in_mat[0] = req_row_0;
   assign in_mat[1] = req_row_1;
   assign in_mat[2] = req_row_2;
   assign in_mat[3] = req_row_3;

   minv_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_mat    (in_mat),
      .cof_valid (cof_valid),
      .cof       (cof),
      .cof_col0  (cof_col0)
   );

   minv_det u_det (
      .clock     (clock),
      .reset     (reset),
      .cof_valid (cof_valid),
      .cof       (cof),
      .cof_col0  (cof_col0),
      .det_ctl   (det_ctl),
      .dmag      (dmag),
      .cm        (cm),
      .neg       (neg)
   );

   // step through rows 0..3; a fresh matrix lands at the earliest as row 3 leaves
   always_comb begin
      ser_active_in = ser_active_ff;
      ser_row_in    = ser_row_ff;
      if (ser_active_ff) begin
         ser_row_in = ser_row_ff + 2'd1;
         if (ser_row_ff == LAST_ROW) begin
            ser_active_in = 1'b0;
         end
      end
      if (det_ctl.valid) begin
         ser_active_in = 1'b1;
         ser_row_in    = 2'd0;
      end
   end

   // divider entry: numerator is the cofactor magnitude scaled by 2^24
   always_comb begin
      div_in.valid    = ser_active_ff;
      div_in.row      = ser_row_ff;
      div_in.singular = hold_sing_ff;
      div_in.dmag     = hold_dmag_ff;
      div_in.sat      = '0;
      div_in.quo      = '0;
      for (int c = 0; c < N; c++) begin
         div_in.neg[c] = hold_neg_ff[ser_row_ff][c];
         div_in.rem[c] = NUM_W'(hold_cm_ff[ser_row_ff][c]) << FRAC_SHIFT;
      end
   end

   minv_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   // sign, saturation and singular zeroing
   always_comb begin
      for (int c = 0; c < N; c++) begin
         if (div_out.singular) begin
            rsp_col_in[c] = '0;
         end else if (div_out.neg[c]) begin
            rsp_col_in[c] = div_out.sat[c] ? SAT_NEG : -(32'(div_out.quo[c]));
         end else begin
            rsp_col_in[c] = div_out.sat[c] ? SAT_POS : 32'(div_out.quo[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_cnt_ff   <= 2'd0;
         ser_active_ff <= 1'b0;
         ser_row_ff    <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_cnt_ff   <= hold_cnt_in;
         ser_active_ff <= ser_active_in;
         ser_row_ff    <= ser_row_in;
         rsp_valid_ff  <= div_out.valid;
      end
      if (det_ctl.valid) begin
         hold_cm_ff   <= cm;
         hold_neg_ff  <= neg;
         hold_dmag_ff <= dmag;
         hold_sing_ff <= det_ctl.singular;
      end
      rsp_row_ff  <= div_out.row;
      rsp_sing_ff <= div_out.singular;
      rsp_last_ff <= div_out.valid && (div_out.row == LAST_ROW);
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_col_0     = rsp_col_ff[0];
   assign rsp_col_1     = rsp_col_ff[1];
   assign rsp_col_2     = rsp_col_ff[2];
   assign rsp_col_3     = rsp_col_ff[3];
   assign rsp_singular  = rsp_sing_ff;
   assign rsp_last_row  = rsp_last_ff;

   // a taken transaction blocks the next start for the following cycles
   `MINV_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "busy not raised after start")
   // rows of one matrix leave back to back in order
   `MINV_ASSERT(a_rows_in_order, (rsp_valid && rsp_row_index != LAST_ROW) |=> (rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1), "inverse rows out of order")
   // a new matrix never overwrites the serialiser before row 3 has gone
   `MINV_ASSERT_NEVER(a_hold_overrun, det_ctl.valid && ser_active_ff && ser_row_ff != LAST_ROW, "serialiser overrun")

endmodule
